### hw/rtl/assert_macros.svh
// Assertion macros shared by the contact supervisor RTL.
// No dependencies; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property disabled while the active-low reset is asserted, custom message.
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked property with a fixed message.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    `ASSERT_CLK_MSG(lbl, clk, rst_n, prop, "assertion failed")
`else
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`endif
`endif

### hw/rtl/lcs_pkg.sv
// Shared types, constants and helper function of the contact supervisor.
// No dependencies; imported by the lane, merge and top-level modules.
package lcs_pkg;

    localparam int MAX_LEGS      = 6;
    localparam int LEG_COUNT_DEF = 6;

    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 168;

    localparam logic [4:0] CONF_FULL     = 5'd20;
    localparam logic [9:0] DUTY_MIN      = 10'd51;
    localparam logic [9:0] DUTY_MAX      = 10'd973;
    localparam logic [8:0] HEIGHT_STEP   = 9'd10;
    localparam logic [8:0] HEIGHT_CAP    = 9'd80;
    localparam logic [9:0] STEP_FLOOR    = 10'd40;
    localparam logic [9:0] CADENCE_FLOOR = 10'd15;

    localparam logic [2:0] DEGRADED_LIMIT_RST = 3'd2;
    localparam logic [4:0] LOW_CONF_LIMIT_RST = 5'd8;

    // Configuration register indexes
    localparam logic [1:0] REG_DEGRADED_LIMIT = 2'd0;
    localparam logic [1:0] REG_LOW_CONF_LIMIT = 2'd1;

    typedef struct packed {
        logic       contact;
        logic       stance;
        logic [9:0] phase;
        logic [9:0] duty;
        logic [7:0] height;
        logic [9:0] len;
    } t_lane_in;

    typedef struct packed {
        logic       touch;
        logic       slip;
        logic       stance;
        logic       degraded;
        logic [4:0] conf;
        logic [7:0] height;
        logic [9:0] len;
    } t_lane_res;

    typedef struct packed {
        logic        derate;
        logic [9:0]  cadence;
        logic [59:0] len;
        logic [47:0] height;
        logic [29:0] conf;
        logic [5:0]  slip;
        logic [5:0]  touch;
        logic [5:0]  managed;
    } t_result;

    // floor(x / 5) by reciprocal multiply, exact for every 16-bit x
    function automatic logic [13:0] div5(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd52429;
        return p[31:18];
    endfunction

endpackage

### hw/rtl/lcs_lane.sv
// One leg of the contact supervisor: per-leg state and first-stage result register.
// Depends on lcs_pkg.
module lcs_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lcs_pkg::t_lane_in i_lane,
    input  logic [4:0]        i_low_conf_limit,
    output lcs_pkg::t_lane_res o_res
);
    import lcs_pkg::*;

    logic       r_last_contact;
    logic       r_last_stance;
    logic [1:0] r_missed;
    logic [1:0] r_tally;
    logic [4:0] r_conf;
    t_lane_res  r_res;

    logic [1:0]  n_missed;
    logic [1:0]  n_tally;
    logic [4:0]  n_conf;
    t_lane_res   n_res;

    logic [9:0]  duty;
    logic [9:0]  diff;
    logic [12:0] prog5;
    logic [10:0] remain;
    logic        late;
    logic        td;
    logic        slip;
    logic        search;
    logic [8:0]  hsum;
    logic [13:0] len9;
    logic [13:0] q;
    logic [9:0]  lenq;

    always_comb begin
        priority if (i_lane.duty < DUTY_MIN) begin
            duty = DUTY_MIN;
        end else if (i_lane.duty > DUTY_MAX) begin
            duty = DUTY_MAX;
        end else begin
            duty = i_lane.duty;
        end

        // 5*(phase - duty) >= 1024 - duty, i.e. swing at least 20 percent done
        diff   = i_lane.phase - duty;
        prog5  = {1'b0, diff, 2'b00} + 13'(diff);
        remain = 11'd1024 - {1'b0, duty};
        late   = (i_lane.phase >= duty) && (prog5 >= 13'(remain));

        td   = !i_lane.stance && !r_last_contact && i_lane.contact && late;
        slip = i_lane.stance && !i_lane.contact;

        n_tally = r_tally;
        if (slip && r_tally != 2'd2) begin
            n_tally = r_tally + 2'd1;
        end

        priority if (slip) begin
            n_conf = (r_conf >= 5'd4) ? r_conf - 5'd4 : 5'd0;
        end else if (i_lane.stance && i_lane.contact) begin
            n_conf = (r_conf + 5'd2 > CONF_FULL) ? CONF_FULL : r_conf + 5'd2;
        end else begin
            n_conf = (r_conf != 5'd0) ? r_conf - 5'd1 : 5'd0;
        end

        // a touchdown always has contact, so the contact branch clears it
        priority if (slip && r_last_stance) begin
            n_missed = (r_missed != 2'd3) ? r_missed + 2'd1 : r_missed;
        end else if (i_lane.contact) begin
            n_missed = 2'd0;
        end else begin
            n_missed = r_missed;
        end

        search = n_missed[1];

        hsum = {1'b0, i_lane.height} + HEIGHT_STEP;
        len9 = 14'(i_lane.len) * 14'd9;
        q    = div5({3'b000, len9[13:1]});
        lenq = q[9:0];

        n_res.touch    = td;
        n_res.slip     = slip;
        n_res.stance   = i_lane.stance;
        n_res.conf     = n_conf;
        n_res.degraded = n_tally[1] || search || (n_conf < i_low_conf_limit);
        if (search) begin
            n_res.height = (hsum > HEIGHT_CAP) ? HEIGHT_CAP[7:0] : hsum[7:0];
            n_res.len    = (lenq < STEP_FLOOR) ? STEP_FLOOR : lenq;
        end else begin
            n_res.height = i_lane.height;
            n_res.len    = i_lane.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_contact <= 1'b0;
            r_last_stance  <= 1'b0;
            r_missed       <= 2'd0;
            r_tally        <= 2'd0;
            r_conf         <= CONF_FULL;
        end else if (i_accept) begin
            r_last_contact <= i_lane.contact;
            r_last_stance  <= i_lane.stance;
            r_missed       <= n_missed;
            r_tally        <= n_tally;
            r_conf         <= n_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### hw/rtl/lcs_merge.sv
// Merge stage: degraded-leg count, gait derating and the output register.
// Depends on lcs_pkg.
module lcs_merge #(
    parameter int LEG_COUNT = lcs_pkg::LEG_COUNT_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  lcs_pkg::t_lane_res [lcs_pkg::MAX_LEGS-1:0]  i_res,
    input  logic [9:0]                                  i_cadence,
    input  logic [2:0]                                  i_degraded_limit,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output lcs_pkg::t_result                            o_result
);
    import lcs_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    logic [2:0]  degraded_cnt;
    logic        derate;
    logic [13:0] cad_q;
    logic [9:0]  cad_d;
    logic [9:0]  len_out [MAX_LEGS];

    always_comb begin
        degraded_cnt = 3'd0;
        for (int i = 0; i < MAX_LEGS; i++) begin
            degraded_cnt = degraded_cnt + 3'(i_res[i].degraded);
        end
        derate = degraded_cnt >= i_degraded_limit;
        // floor(8c/10) = floor(4c/5)
        cad_q  = div5({4'b0000, i_cadence, 2'b00});
        cad_d  = (cad_q[9:0] < CADENCE_FLOOR) ? CADENCE_FLOOR : cad_q[9:0];
    end

    for (genvar g = 0; g < MAX_LEGS; g++) begin : g_len
        if (g < LEG_COUNT) begin : g_used
            logic [14:0] l17;
            logic [13:0] lq;
            // floor(85*len/100) = floor(floor(17*len/4)/5)
            always_comb begin
                l17 = 15'(i_res[g].len) * 15'd17;
                lq  = div5({3'b000, l17[14:2]});
                if (derate) begin
                    len_out[g] = (lq[9:0] < STEP_FLOOR) ? STEP_FLOOR : lq[9:0];
                end else begin
                    len_out[g] = i_res[g].len;
                end
            end
        end else begin : g_unused
            assign len_out[g] = 10'd0;
        end
    end

    always_comb begin
        n_result.derate  = derate;
        n_result.cadence = derate ? cad_d : i_cadence;
        for (int i = 0; i < MAX_LEGS; i++) begin
            n_result.managed[i]            = i_res[i].stance | i_res[i].touch;
            n_result.touch[i]              = i_res[i].touch;
            n_result.slip[i]               = i_res[i].slip;
            n_result.conf[5*i +: 5]        = i_res[i].conf;
            n_result.height[8*i +: 8]      = i_res[i].height;
            n_result.len[10*i +: 10]       = len_out[i];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/legged_contact_supervisor.sv
// Top level of the legged contact supervisor: stream ports, config registers, lanes, merge.
// Depends on lcs_pkg, lcs_lane, lcs_merge and assert_macros.svh.
//
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready   | one control tick, 250 bits
// m_axis    | out       | m_axis_tvalid / m_axis_tready   | one supervised result, 167 bits
// cfg       | in        | i_cfg_valid / o_cfg_ready       | register index, write data
//
// Flow: one tick enters per cycle while s_axis_tready is high; an accepted request passes
//   the lane register, then the merge output register.
// The two stages are the per-leg lanes (duty clamp, swing compare, state update, foot search)
//   and the merge (degraded count, cadence and step derating by reciprocal multiplies).
// Reset: synchronous, active low; clears per-leg history, confidence to full (20), config
//   registers to their defaults and both stage valids. No clearing pass is needed.
// Stalls: with m_axis_tready low the output register holds, the lane stage still takes one
//   more request, then s_axis_tready drops until the result is taken.
// The config port is always ready; write it only while no request is in flight.
module legged_contact_supervisor #(
    parameter int LEG_COUNT = lcs_pkg::LEG_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] contact_bits, [11:6] stance_bits, [71:12] phase_lanes, [131:72] duty_lanes,
    // [179:132] swing_height_lanes, [239:180] step_length_lanes, [249:240] cadence_in,
    // [255:250] zero
    input  logic [lcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] managed_stance_bits, [11:6] touchdown_bits, [17:12] slip_bits,
    // [47:18] confidence_lanes, [95:48] swing_height_out, [155:96] step_length_out,
    // [165:156] cadence_out, [166] derate_request, [167] zero
    output logic [lcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [4:0]                       i_cfg_data
);
    import lcs_pkg::*;

`include "assert_macros.svh"

    // unpacked input fields
    logic [5:0]  in_contact;
    logic [5:0]  in_sched;
    logic [59:0] in_phase;
    logic [59:0] in_duty;
    logic [47:0] in_height;
    logic [59:0] in_len;
    logic [9:0]  in_cadence;

    assign in_contact = s_axis_tdata[5:0];
    assign in_sched   = s_axis_tdata[11:6];
    assign in_phase   = s_axis_tdata[71:12];
    assign in_duty    = s_axis_tdata[131:72];
    assign in_height  = s_axis_tdata[179:132];
    assign in_len     = s_axis_tdata[239:180];
    assign in_cadence = s_axis_tdata[249:240];

    // configuration registers
    logic [2:0] r_degraded_limit;
    logic [4:0] r_low_conf_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degraded_limit <= DEGRADED_LIMIT_RST;
            r_low_conf_limit <= LOW_CONF_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEGRADED_LIMIT) begin
                r_degraded_limit <= i_cfg_data[2:0];
            end else if (i_cfg_index == REG_LOW_CONF_LIMIT) begin
                r_low_conf_limit <= i_cfg_data;
            end
        end
    end

    // lane stage control: the lane registers load on every accepted request
    logic       r_s1_valid;
    logic [9:0] r_s1_cadence;
    logic       w_merge_ready;
    logic       w_accept;

    assign s_axis_tready = !r_s1_valid || w_merge_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_merge_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cadence <= in_cadence;
        end
    end

    // one lane per leg; legs beyond LEG_COUNT read as all-zero results
    t_lane_res [MAX_LEGS-1:0] w_res;

    for (genvar g = 0; g < MAX_LEGS; g++) begin : g_leg
        if (g < LEG_COUNT) begin : g_used
            t_lane_in lane_in;
            assign lane_in.contact = in_contact[g];
            assign lane_in.stance  = in_sched[g];
            assign lane_in.phase   = in_phase[10*g +: 10];
            assign lane_in.duty    = in_duty[10*g +: 10];
            assign lane_in.height  = in_height[8*g +: 8];
            assign lane_in.len     = in_len[10*g +: 10];

            lcs_lane u_lane (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_accept         (w_accept),
                .i_lane           (lane_in),
                .i_low_conf_limit (r_low_conf_limit),
                .o_res            (w_res[g])
            );
        end else begin : g_unused
            assign w_res[g] = '0;
        end
    end

    t_result w_result;

    lcs_merge #(
        .LEG_COUNT (LEG_COUNT)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_s1_valid),
        .o_ready          (w_merge_ready),
        .i_res            (w_res),
        .i_cadence        (r_s1_cadence),
        .i_degraded_limit (r_degraded_limit),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_result         (w_result)
    );

    assign m_axis_tdata = {1'b0, w_result};

    // a stalled lane stage must keep its request
    `ASSERT_CLK_MSG(a_s1_hold, i_clk, i_rst_n, (r_s1_valid && !w_merge_ready) |=> r_s1_valid,
        "lane stage dropped a stalled request")
    // touchdown needs swing, slip needs stance: never both on one leg
    `ASSERT_CLK(a_td_slip_excl, i_clk, i_rst_n,
        m_axis_tvalid |-> ((w_result.touch & w_result.slip) == 6'd0))
    // every touchdown forces stance in the managed schedule
    `ASSERT_CLK(a_td_forces_stance, i_clk, i_rst_n,
        m_axis_tvalid |-> ((w_result.touch & ~w_result.managed) == 6'd0))
    // derated cadence respects its floor
    `ASSERT_CLK(a_cadence_floor, i_clk, i_rst_n,
        (m_axis_tvalid && w_result.derate) |-> (w_result.cadence >= CADENCE_FLOOR))

endmodule
